[src/line_pattern_filter_assert.svh]
// Assertion macros shared by the line pattern filter RTL.
// Included by modules that carry concurrent checks; needs no package.
`ifndef LINE_PATTERN_FILTER_ASSERT_SVH
`define LINE_PATTERN_FILTER_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define LPF_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("line_pattern_filter: same-cycle check failed");

// Next-cycle implication, checked out of reset.
`define LPF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("line_pattern_filter: next-cycle check failed");

`endif

[src/lpf_pkg.sv]
// Package for the line pattern filter: configuration types, register
// indexes and shared constants. No dependencies.
`default_nettype none

package lpf_pkg;

	localparam int unsigned PATTERN_BYTES = 16;
	localparam int unsigned PAT_IDX_W     = 4;
	localparam int unsigned LEN_W         = 5;
	localparam int unsigned CFG_DATA_W    = 64;
	localparam int unsigned CFG_IDX_W     = 3;
	localparam int unsigned LINE_W        = 16;
	localparam logic [7:0]  SPACE_BYTE    = 8'h20;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PATTERN_LOW  = 3'd0,
		REG_PATTERN_HIGH = 3'd1,
		REG_PATTERN_LEN  = 3'd2,
		REG_WHOLE_WORD   = 3'd3,
		REG_EXCLUDE      = 3'd4
	} cfg_reg_t;

	typedef struct packed {
		logic [CFG_DATA_W-1:0] pattern_high;
		logic [CFG_DATA_W-1:0] pattern_low;
		logic [LEN_W-1:0]      pattern_length;
		logic                  whole_word;
		logic                  exclude;
	} cfg_t;

	typedef struct packed {
		logic window_hit;
		logic left_bound;
	} match_t;

endpackage

`default_nettype wire

[src/lpf_cfg.sv]
// Configuration register bank of the line pattern filter.
// Depends on lpf_pkg for the register indexes and the cfg_t bundle.
`default_nettype none

module lpf_cfg import lpf_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_write,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output cfg_t                  cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pattern_low    <= '0;
			cfg_q.pattern_high   <= '0;
			cfg_q.pattern_length <= LEN_W'(1);
			cfg_q.whole_word     <= 1'b0;
			cfg_q.exclude        <= 1'b0;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_PATTERN_LOW:  cfg_q.pattern_low    <= cfg_data;
				REG_PATTERN_HIGH: cfg_q.pattern_high   <= cfg_data;
				REG_PATTERN_LEN:  cfg_q.pattern_length <= cfg_data[LEN_W-1:0];
				REG_WHOLE_WORD:   cfg_q.whole_word     <= cfg_data[0];
				REG_EXCLUDE:      cfg_q.exclude        <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

[src/lpf_match.sv]
// Recent-byte window and parallel pattern compare of the line pattern filter.
// Depends on lpf_pkg for cfg_t, match_t and the space byte.
`default_nettype none

module lpf_match import lpf_pkg::*; #(
	parameter int unsigned MAX_PATTERN_BYTES = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       shift,
	input  logic       clear,
	input  logic [7:0] data,
	input  cfg_t       cfg,
	output match_t     hit
);

	localparam int unsigned DEPTH = MAX_PATTERN_BYTES + 1;
	localparam int unsigned IDX_W = $clog2(DEPTH);
	localparam int unsigned SEEN_W = $clog2(DEPTH + 1);

	logic [7:0]           window_q [DEPTH];
	logic [7:0]           win_next [DEPTH];
	logic [SEEN_W-1:0]    seen_q;
	logic [SEEN_W-1:0]    seen_next;
	logic [LEN_W-1:0]     len;
	logic [LEN_W-1:0]     seen_ext;
	logic [7:0]           pat [PATTERN_BYTES];
	logic [2*CFG_DATA_W-1:0] pat_word;
	logic                 all_eq;

	always_ff @(posedge clk) begin
		if (shift) begin
			for (int k = 0; k < DEPTH; k++) begin
				window_q[k] <= win_next[k];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q <= '0;
		end else if (clear) begin
			seen_q <= '0;
		end else if (shift) begin
			seen_q <= seen_next;
		end
	end

	always_comb begin
		win_next[0] = data;
		for (int k = 1; k < DEPTH; k++) begin
			win_next[k] = window_q[k-1];
		end
		seen_next = (seen_q == SEEN_W'(DEPTH)) ? seen_q : seen_q + SEEN_W'(1);
		seen_ext  = LEN_W'(seen_next);
	end

	always_comb begin
		if (cfg.pattern_length == '0) begin
			len = LEN_W'(1);
		end else if (cfg.pattern_length > LEN_W'(MAX_PATTERN_BYTES)) begin
			len = LEN_W'(MAX_PATTERN_BYTES);
		end else begin
			len = cfg.pattern_length;
		end
	end

	always_comb begin
		pat_word = {cfg.pattern_high, cfg.pattern_low};
		for (int i = 0; i < PATTERN_BYTES; i++) begin
			pat[i] = pat_word[8*i +: 8];
		end
	end

	// Newest byte sits at window position 0 and lines up with the last pattern byte.
	always_comb begin
		logic [LEN_W-1:0] pidx;
		all_eq = 1'b1;
		for (int j = 0; j < MAX_PATTERN_BYTES; j++) begin
			pidx = len - LEN_W'(1) - LEN_W'(j);
			if (LEN_W'(j) < len && win_next[j] != pat[pidx[PAT_IDX_W-1:0]]) begin
				all_eq = 1'b0;
			end
		end
	end

	assign hit.window_hit = all_eq && (seen_ext >= len);
	assign hit.left_bound = (seen_ext == len) || (win_next[len[IDX_W-1:0]] == SPACE_BYTE);

endmodule

`default_nettype wire

[src/line_pattern_filter.sv]
// Top level of the line pattern filter: input register, line state, result register.
// Depends on lpf_pkg, lpf_cfg, lpf_match and line_pattern_filter_assert.svh.
`default_nettype none

// Takes one character beat per clock and gives one result beat per end-of-line
// beat: line_selected and the zero-based line_number. Each beat is registered,
// compared against the pattern over a window of the last MAX_PATTERN_BYTES+1
// bytes, and the result is registered, so an end-of-line beat passes the input
// register and then the result register, entering it when that register is free.
// Sustained rate is one beat per cycle; char_stall rises only while an
// end-of-line beat is held in the input register behind a result that
// result_stall keeps waiting. Configuration writes take effect once registered;
// the user must make them while no beat is in flight; the block does not enforce it.

module line_pattern_filter import lpf_pkg::*; #(
	parameter int unsigned MAX_PATTERN_BYTES = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_write,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  char_valid,
	output logic                  char_stall,
	input  logic [7:0]            character,
	input  logic                  end_of_line,
	output logic                  result_valid,
	input  logic                  result_stall,
	output logic                  line_selected,
	output logic [LINE_W-1:0]     line_number
);

	cfg_t              cfg;
	match_t            hit;
	logic              valid_s1;
	logic [7:0]        char_s1;
	logic              eol_s1;
	logic              fire_s1;
	logic              out_free;
	logic              accept;
	logic              awaiting_q;
	logic              found_q;
	logic [LINE_W-1:0] line_q;
	logic              out_valid_q;
	logic              selected_q;
	logic [LINE_W-1:0] number_q;

	lpf_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	lpf_match #(
		.MAX_PATTERN_BYTES (MAX_PATTERN_BYTES)
	) u_match (
		.clk    (clk),
		.arst_n (arst_n),
		.shift  (fire_s1 && !eol_s1),
		.clear  (fire_s1 && eol_s1),
		.data   (char_s1),
		.cfg    (cfg),
		.hit    (hit)
	);

	assign out_free   = !out_valid_q || !result_stall;
	assign fire_s1    = valid_s1 && (!eol_s1 || out_free);
	assign char_stall = valid_s1 && !fire_s1;
	assign accept     = char_valid && !char_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (fire_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			char_s1 <= character;
			eol_s1  <= end_of_line;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			awaiting_q <= 1'b0;
			found_q    <= 1'b0;
			line_q     <= '0;
		end else if (fire_s1) begin
			if (eol_s1) begin
				awaiting_q <= 1'b0;
				found_q    <= 1'b0;
				line_q     <= line_q + LINE_W'(1);
			end else begin
				found_q    <= found_q || (awaiting_q && char_s1 == SPACE_BYTE)
					|| (hit.window_hit && !cfg.whole_word);
				awaiting_q <= hit.window_hit && cfg.whole_word && hit.left_bound;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire_s1 && eol_s1) begin
			out_valid_q <= 1'b1;
		end else if (!result_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1 && eol_s1) begin
			selected_q <= (found_q || awaiting_q) ^ cfg.exclude;
			number_q   <= line_q;
		end
	end

	assign result_valid  = out_valid_q;
	assign line_selected = selected_q;
	assign line_number   = number_q;

`include "line_pattern_filter_assert.svh"

	`LPF_ASSERT_NEXT(a_byte_no_result, clk, arst_n, fire_s1 && !eol_s1 && !result_stall, !result_valid)
	`LPF_ASSERT_NEXT(a_eol_result, clk, arst_n, fire_s1 && eol_s1, result_valid && line_number == $past(line_q))
	`LPF_ASSERT_NOW(a_stall_cause, clk, arst_n, char_stall, valid_s1 && eol_s1 && out_valid_q && result_stall)
	`LPF_ASSERT_NEXT(a_line_hold, clk, arst_n, !(fire_s1 && eol_s1), $stable(line_q))

endmodule

`default_nettype wire
